// ----- rtl/jsrl_pkg.sv -----
// jsrl_pkg: types, marker codes, status codes and phase codes for the
// jpeg scan region locator. No dependencies.

package jsrl_pkg;

   localparam int DEFAULT_OFFSET_BITS = 32;
   localparam int RESULT_OFFSET_BITS  = 32;

   // second byte of each marker of interest
   localparam logic [7:0] CODE_FILL = 8'hFF;
   localparam logic [7:0] CODE_SOF0 = 8'hC0;
   localparam logic [7:0] CODE_RST7 = 8'hD7;
   localparam logic [7:0] CODE_SOI  = 8'hD8;
   localparam logic [7:0] CODE_EOI  = 8'hD9;
   localparam logic [7:0] CODE_SOS  = 8'hDA;
   localparam logic [7:0] CODE_DQT  = 8'hDB;
   localparam logic [7:0] CODE_APP5 = 8'hE5;
   localparam logic [7:0] CODE_COM  = 8'hFE;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_FORMAT = 2'd1;
   localparam logic [1:0] STATUS_APP5   = 2'd2;

   localparam logic [2:0] PH_FIRST    = 3'd0;
   localparam logic [2:0] PH_MARKER   = 3'd1;
   localparam logic [2:0] PH_LEN_HI   = 3'd2;
   localparam logic [2:0] PH_LEN_LO   = 3'd3;
   localparam logic [2:0] PH_SKIP     = 3'd4;
   localparam logic [2:0] PH_EOI_SCAN = 3'd5;

   typedef struct packed {
      logic [2:0]  phase;
      logic [15:0] skip_remaining;
      logic [7:0]  length_high;
      logic        last_was_ff;
      logic        verdict_given;
   } parse_state_type;

   typedef struct packed {
      logic       give;
      logic [1:0] status;
      logic       sos_capture;
      logic       file_done;
   } step_ctl_type;

   localparam parse_state_type PARSE_STATE_RESET = '{
      phase:          PH_FIRST,
      skip_remaining: 16'd0,
      length_high:    8'd0,
      last_was_ff:    1'b0,
      verdict_given:  1'b0
   };

endpackage

// ----- rtl/jsrl_step.sv -----
// jsrl_step: next-state and verdict logic of the marker walk for one byte.
// Depends on jsrl_pkg.

module jsrl_step (
   input  jsrl_pkg::parse_state_type state,
   input  logic [7:0]                data_byte,
   input  logic                      end_of_file,
   input  logic                      reject_app5,
   output jsrl_pkg::parse_state_type state_next,
   output jsrl_pkg::step_ctl_type    ctl
);

   jsrl_pkg::parse_state_type nxt;
   logic                      give;
   logic [1:0]                status;
   logic                      sos_capture;
   logic [15:0]               seg_len;
   logic [15:0]               skip_len;
   logic                      in_range;

   assign seg_len  = {state.length_high, data_byte};
   assign skip_len = seg_len - 16'd2;
   assign in_range = (data_byte >= jsrl_pkg::CODE_SOF0 && data_byte <= jsrl_pkg::CODE_RST7)
                  || (data_byte >= jsrl_pkg::CODE_DQT && data_byte <= jsrl_pkg::CODE_COM);

   always_comb begin
      nxt         = state;
      give        = 1'b0;
      status      = jsrl_pkg::STATUS_FORMAT;
      sos_capture = 1'b0;

      if (!state.verdict_given) begin
         case (state.phase)
            jsrl_pkg::PH_FIRST, jsrl_pkg::PH_MARKER: begin
               if (state.last_was_ff) begin
                  if (data_byte != jsrl_pkg::CODE_FILL) begin
                     nxt.last_was_ff = 1'b0;
                     if (state.phase == jsrl_pkg::PH_FIRST) begin
                        if (data_byte == jsrl_pkg::CODE_SOI) begin
                           nxt.phase = jsrl_pkg::PH_MARKER;
                        end else begin
                           give = 1'b1;
                        end
                     end else if (data_byte == jsrl_pkg::CODE_SOS) begin
                        sos_capture = 1'b1;
                        nxt.phase   = jsrl_pkg::PH_EOI_SCAN;
                     end else if (data_byte == jsrl_pkg::CODE_EOI) begin
                        give = 1'b1;
                     end else if (reject_app5 && data_byte == jsrl_pkg::CODE_APP5) begin
                        give   = 1'b1;
                        status = jsrl_pkg::STATUS_APP5;
                     end else if (in_range) begin
                        nxt.phase = jsrl_pkg::PH_LEN_HI;
                     end else begin
                        give = 1'b1;
                     end
                  end
               end else if (data_byte == jsrl_pkg::CODE_FILL) begin
                  nxt.last_was_ff = 1'b1;
               end else begin
                  give = 1'b1;
               end
            end
            jsrl_pkg::PH_LEN_HI: begin
               nxt.length_high = data_byte;
               nxt.phase       = jsrl_pkg::PH_LEN_LO;
            end
            jsrl_pkg::PH_LEN_LO: begin
               // length counts its own two bytes
               if (seg_len < 16'd2) begin
                  give = 1'b1;
               end else begin
                  nxt.skip_remaining = skip_len;
                  nxt.phase = (skip_len != 16'd0) ? jsrl_pkg::PH_SKIP : jsrl_pkg::PH_MARKER;
               end
            end
            jsrl_pkg::PH_SKIP: begin
               nxt.skip_remaining = state.skip_remaining - 16'd1;
               if (state.skip_remaining == 16'd1) begin
                  nxt.phase = jsrl_pkg::PH_MARKER;
               end
            end
            jsrl_pkg::PH_EOI_SCAN: begin
               if (state.last_was_ff && data_byte == jsrl_pkg::CODE_EOI) begin
                  give   = 1'b1;
                  status = jsrl_pkg::STATUS_OK;
               end else begin
                  nxt.last_was_ff = (data_byte == jsrl_pkg::CODE_FILL);
               end
            end
            default: begin
               give = 1'b1;
            end
         endcase
      end

      if (give) begin
         nxt.verdict_given = 1'b1;
      end

      // file ended with no verdict yet
      if (end_of_file && !state.verdict_given && !give) begin
         give   = 1'b1;
         status = jsrl_pkg::STATUS_FORMAT;
      end
   end

   assign state_next      = end_of_file ? jsrl_pkg::PARSE_STATE_RESET : nxt;
   assign ctl.give        = give;
   assign ctl.status      = status;
   assign ctl.sos_capture = sos_capture;
   assign ctl.file_done   = end_of_file;

endmodule

// ----- rtl/jpeg_scan_region_locator.sv -----
// jpeg_scan_region_locator: top level, input register, offset counters and
// result register around the per-byte marker walk. Depends on jsrl_pkg, jsrl_step.
//
//   channel   ports                                                role
//   req       req_valid, req_stall, req_data_byte, req_end_of_file file bytes in
//   rsp       rsp_valid, rsp_stall, rsp_status, rsp_scan_*         one verdict per file
//   csr       csr_write_enable, csr_write_data                     reject_app5 flag
//
// One byte per cycle while the result is not stalled; a byte is held in the
// input register, and its verdict, if any, is registered in the result
// register when that byte is processed and is presented from there.
// Synchronous active-high reset clears parse state, offsets and the flag.
// A stalled result holds both stages; the input takes a byte whenever its
// register is empty or moving on.

module jpeg_scan_region_locator #(
   parameter int OFFSET_BITS = jsrl_pkg::DEFAULT_OFFSET_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_file,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_scan_start,
   output logic [31:0] rsp_scan_end,
   input  logic        csr_write_enable,
   input  logic        csr_write_data
);

   localparam int RES_BITS = jsrl_pkg::RESULT_OFFSET_BITS;

   logic                      in_valid_ff, in_valid_in;
   logic [7:0]                in_byte_ff;
   logic                      in_eof_ff;
   logic                      advance;
   logic                      process;
   logic                      req_accept;

   jsrl_pkg::parse_state_type state_ff, state_in;
   jsrl_pkg::step_ctl_type    ctl;

   logic [OFFSET_BITS-1:0]    byte_offset_ff, byte_offset_in;
   logic [OFFSET_BITS-1:0]    sos_offset_ff, sos_offset_in;
   logic [OFFSET_BITS-1:0]    end_offset;
   logic [63:0]               sos_wide;
   logic [63:0]               end_wide;
   logic                      reject_app5_ff;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [1:0]                rsp_status_ff;
   logic [RES_BITS-1:0]       rsp_start_ff;
   logic [RES_BITS-1:0]       rsp_end_ff;

   assign advance    = !(rsp_valid_ff && rsp_stall);
   assign process    = in_valid_ff && advance;
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;

   jsrl_step u_step (
      .state       (state_ff),
      .data_byte   (in_byte_ff),
      .end_of_file (in_eof_ff),
      .reject_app5 (reject_app5_ff),
      .state_next  (state_in),
      .ctl         (ctl)
   );

   assign end_offset     = byte_offset_ff + OFFSET_BITS'(1);
   assign byte_offset_in = ctl.file_done ? '0 : end_offset;
   assign sos_offset_in  = ctl.file_done   ? '0 :
                           ctl.sos_capture ? byte_offset_ff - OFFSET_BITS'(1) :
                                             sos_offset_ff;
   assign sos_wide       = 64'(sos_offset_ff);
   assign end_wide       = 64'(end_offset);
   // a finished result leaves when taken even with nothing new behind it
   assign rsp_valid_in   = advance ? (process && ctl.give) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         state_ff       <= jsrl_pkg::PARSE_STATE_RESET;
         byte_offset_ff <= '0;
         sos_offset_ff  <= '0;
         reject_app5_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            reject_app5_ff <= csr_write_data;
         end
         if (process) begin
            state_ff       <= state_in;
            byte_offset_ff <= byte_offset_in;
            sos_offset_ff  <= sos_offset_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_data_byte;
         in_eof_ff  <= req_end_of_file;
      end
      if (process && ctl.give) begin
         rsp_status_ff <= ctl.status;
         if (ctl.status == jsrl_pkg::STATUS_OK) begin
            rsp_start_ff <= sos_wide[RES_BITS-1:0];
            rsp_end_ff   <= end_wide[RES_BITS-1:0];
         end else begin
            rsp_start_ff <= '0;
            rsp_end_ff   <= '0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_scan_start = rsp_start_ff;
   assign rsp_scan_end   = rsp_end_ff;

endmodule
